@@ sv/rpt_pkg.sv @@
// Package for the running percentile threshold block.
// Holds sizes, the controller/datapath command types and the saturating increment.
// No dependencies.
package rpt_pkg;

	localparam int NUM_BINS     = 1024;
	localparam int COUNT_BITS   = 32;
	localparam int SCORE_BITS   = 10;
	localparam int PCT_BITS     = 7;
	localparam int PCT_RESET    = 50;
	localparam int DIVISOR      = 100;
	localparam int BIN_BITS     = $clog2(NUM_BINS);
	localparam int PROD_BITS    = COUNT_BITS + PCT_BITS;
	localparam int DIFF_BITS    = PROD_BITS + 2;

	typedef logic [BIN_BITS-1:0]   bin_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SCORE_BITS-1:0] score_t;
	typedef logic [PCT_BITS-1:0]   pct_t;

	typedef struct packed {
		logic load_item;
		logic use_bin;
		bin_t addr;
		logic we;
		logic clr;
		logic mul_load;
		logic acc;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
	} dp_stat_t;

	function automatic count_t sat_inc(count_t v);
		return (&v) ? v : v + count_t'(1);
	endfunction

endpackage

@@ sv/rpt_datapath.sv @@
// Datapath: histogram memory, item counter, percent register, rank compare
// and walk accumulator. Driven by rpt_ctrl commands; uses rpt_pkg.
module rpt_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  rpt_pkg::dp_cmd_t cmd,
	output rpt_pkg::dp_stat_t stat,
	input  rpt_pkg::score_t  score,
	input  logic             cfg_we,
	input  rpt_pkg::pct_t    percent
);
	import rpt_pkg::*;

	count_t mem [NUM_BINS];
	count_t rdata_q;
	count_t items_q;
	pct_t   percent_q;
	bin_t   bin_q;
	bin_t   bin_sat;
	bin_t   addr;
	count_t wdata;
	logic [PROD_BITS-1:0] rank_prod;
	logic [PROD_BITS-1:0] bin_scaled;
	logic [DIFF_BITS-1:0] diff_q;
	logic [DIFF_BITS-1:0] diff_next;
	logic                 nz_q;
	logic                 nz_next;

	always_comb begin
		if (int'(score) >= NUM_BINS) begin
			bin_sat = BIN_BITS'(NUM_BINS - 1);
		end else begin
			bin_sat = BIN_BITS'(score);
		end
	end

	assign addr       = cmd.use_bin ? bin_q : cmd.addr;
	assign wdata      = cmd.clr ? '0 : sat_inc(rdata_q);
	assign rank_prod  = PROD_BITS'(percent_q) * PROD_BITS'(items_q);
	assign bin_scaled = PROD_BITS'(rdata_q) * PROD_BITS'(DIVISOR);
	// hit once 100 * (total + 1) exceeds percent * items and total is nonzero
	assign diff_next  = diff_q - DIFF_BITS'(bin_scaled);
	assign nz_next    = nz_q || (rdata_q != '0);
	assign stat.hit   = diff_next[DIFF_BITS-1] && nz_next;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q   <= '0;
			percent_q <= pct_t'(PCT_RESET);
		end else begin
			if (cmd.load_item) begin
				items_q <= sat_inc(items_q);
			end
			if (cfg_we) begin
				percent_q <= percent;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			bin_q <= bin_sat;
		end
		if (cmd.mul_load) begin
			diff_q <= DIFF_BITS'(rank_prod) - DIFF_BITS'(DIVISOR);
			nz_q   <= 1'b0;
		end else if (cmd.acc) begin
			diff_q <= diff_next;
			nz_q   <= nz_next;
		end
	end

endmodule

@@ sv/rpt_ctrl.sv @@
// Controller: clearing pass, update and bin walk sequencing, plus the
// result register. Issues commands to rpt_datapath; uses rpt_pkg.
module rpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output rpt_pkg::score_t   threshold,
	output rpt_pkg::dp_cmd_t  cmd,
	input  rpt_pkg::dp_stat_t stat
);
	import rpt_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t                  state_q;
	bin_t                    cnt_q;
	logic                    issue_q;
	logic                    vld_s1;
	bin_t                    tag_s1;
	bin_t                    res_q;
	logic                    out_valid_q;
	score_t                  thr_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign threshold = thr_q;

	always_comb begin
		cmd      = '0;
		cmd.addr = cnt_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.we  = 1'b1;
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				cmd.load_item = in_valid;
			end
			ST_READ: begin
				cmd.use_bin = 1'b1;
			end
			ST_WRITE: begin
				cmd.use_bin  = 1'b1;
				cmd.we       = 1'b1;
				cmd.mul_load = 1'b1;
			end
			ST_WALK: begin
				cmd.acc = vld_s1;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			tag_s1      <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			thr_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + bin_t'(1);
					if (cnt_q == bin_t'(NUM_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					cnt_q   <= bin_t'(NUM_BINS - 1);
					issue_q <= 1'b1;
					vld_s1  <= 1'b0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (vld_s1 && (stat.hit || tag_s1 == '0)) begin
						res_q   <= stat.hit ? tag_s1 : '0;
						issue_q <= 1'b0;
						vld_s1  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						vld_s1 <= issue_q;
						tag_s1 <= cnt_q;
						if (issue_q) begin
							if (cnt_q == '0) begin
								issue_q <= 1'b0;
							end else begin
								cnt_q <= cnt_q - bin_t'(1);
							end
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						thr_q       <= score_t'(res_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/running_percentile_threshold.sv @@
// Per input transfer: bin read-modify-write, then a walk over the histogram memory at one
// bin per cycle from the top bin down, stopping at the first bin that reaches the rank.
// A new item is taken only after the last result is registered; a stalled older result holds input.
// Reset: a clearing pass over all NUM_BINS bins zeroes the histogram; input stalls meanwhile.
// Top level; instantiates rpt_ctrl and rpt_datapath, uses rpt_pkg.
module running_percentile_threshold (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rpt_pkg::score_t score,
	output logic            out_valid,
	input  logic            out_stall,
	output rpt_pkg::score_t threshold,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  rpt_pkg::pct_t   percent
);
	import rpt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	rpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.threshold (threshold),
		.cmd       (cmd),
		.stat      (stat)
	);

	rpt_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.score   (score),
		.cfg_we  (cfg_valid && cfg_ready),
		.percent (percent)
	);

endmodule

@@ sv/rpt_checker.sv @@
// Port-level checks for running_percentile_threshold, bound to the top level.
// Uses rpt_pkg for field types.
module rpt_port_checks (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input rpt_pkg::score_t threshold,
	input logic            cfg_ready
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken on back-to-back cycles");

	a_no_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared right after an input transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(threshold)))
		else $error("stalled result changed");

	a_cfg_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> cfg_ready)
		else $error("config not ready while idle");

endmodule

bind running_percentile_threshold rpt_port_checks u_rpt_port_checks (.*);

@@ sim/rpt_checker.sv @@
// Checker for running_percentile_threshold: watches the score, threshold and percent
// channels, rebuilds the score histogram on its own and compares every threshold.
// Depends on rpt_pkg for the port types and the reset percent.
module rpt_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  rpt_pkg::score_t score,
	input  logic            out_valid,
	input  logic            out_stall,
	input  rpt_pkg::score_t threshold,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  rpt_pkg::pct_t   percent,
	output int              fail_count,
	output int              pending
);
	import rpt_pkg::*;

	localparam int              HIST_SIZE = 1024;
	localparam longint unsigned TALLY_MAX = 64'hFFFF_FFFF;

	longint unsigned bin_tally [HIST_SIZE];
	longint unsigned seen_total;
	pct_t            pct_now;
	score_t          thr_q [$];
	score_t          exp_thr;
	int              errs;
	int              n_out;

	function automatic longint unsigned bump(longint unsigned v);
		return (v >= TALLY_MAX) ? v : v + 1;
	endfunction

	function automatic score_t record_and_rank(score_t s);
		longint unsigned rank;
		longint unsigned run;
		bin_tally[s] = bump(bin_tally[s]);
		seen_total = bump(seen_total);
		rank = (64'(pct_now) * seen_total) / 100;
		if (rank < 1) begin
			rank = 1;
		end
		run = 0;
		for (int k = HIST_SIZE - 1; k >= 0; k--) begin
			run += bin_tally[k];
			if (run >= rank) begin
				return score_t'(k);
			end
		end
		return '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < HIST_SIZE; b++) begin
				bin_tally[b] = 0;
			end
			seen_total = 0;
			pct_now = pct_t'(PCT_RESET);
			thr_q.delete();
			errs = 0;
			n_out = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pct_now = percent;
			end
			if (in_valid && !in_stall) begin
				thr_q.push_back(record_and_rank(score));
			end
			if (out_valid && !out_stall) begin
				n_out++;
				if (thr_q.size() == 0) begin
					if (errs < 10) begin
						$display("threshold %0d arrived with no prediction pending", threshold);
					end
					errs++;
				end else begin
					exp_thr = thr_q.pop_front();
					if (threshold !== exp_thr) begin
						if (errs < 10) begin
							$display("threshold mismatch on result %0d: expected %0d, got %0d",
								n_out, exp_thr, threshold);
						end
						errs++;
					end
				end
			end
			fail_count <= errs;
			pending <= thr_q.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top for running_percentile_threshold: drives scores and percent writes
// under several pacing modes and reports the verdict from rpt_checker.
// Depends on rpt_pkg, running_percentile_threshold and rpt_checker.
module tb;
	import rpt_pkg::*;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	score_t score;
	logic   out_valid;
	logic   out_stall = 1'b0;
	score_t threshold;
	logic   cfg_valid;
	logic   cfg_ready;
	pct_t   percent;

	int     fail_count;
	int     pending;
	int     send_idle;
	int     stall_rate = 0;
	int     n_sent;
	int     n_cfg;
	score_t hot_base;

	running_percentile_threshold u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.score     (score),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.threshold (threshold),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.percent   (percent)
	);

	rpt_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.score      (score),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.threshold  (threshold),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.percent    (percent),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#30000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_rate);
	end

	task automatic send_score(input score_t s);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		score <= s;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		n_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_percent(input pct_t v);
		drain();
		cfg_valid <= 1'b1;
		percent <= v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	function automatic pct_t phase_pct(int ph);
		case (ph)
			0: return pct_t'(100);
			1: return pct_t'(0);
			2: return pct_t'(127);
			3: return pct_t'(1);
			4: return pct_t'(99);
			7: return pct_t'(50);
			default: return pct_t'($urandom_range(127));
		endcase
	endfunction

	function automatic score_t pick_score(score_t base);
		int unsigned r;
		r = $urandom_range(9);
		case (r)
			0: return '0;
			1: return '1;
			2, 3, 4: return base + score_t'($urandom_range(3));
			default: return score_t'($urandom_range(1023));
		endcase
	endfunction

	initial begin
		in_valid <= 1'b0;
		score <= '0;
		cfg_valid <= 1'b0;
		percent <= pct_t'(PCT_RESET);
		arst_n <= 1'b0;
		send_idle = 0;
		n_sent = 0;
		n_cfg = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_score(10'd0);
		send_score(10'd1023);
		send_score(10'd1023);
		send_score(10'd0);
		send_score(10'd512);
		send_score(10'h155);
		send_score(10'h2AA);
		send_score(10'd1);
		send_score(10'd1022);
		send_score(10'd0);
		write_percent(pct_t'(0));
		send_score(10'd1023);
		send_score(10'd5);
		send_score(10'd700);
		write_percent(pct_t'(127));
		send_score(10'd300);
		send_score(10'd1023);
		write_percent(pct_t'(100));
		send_score(10'd2);
		send_score(10'd1023);
		write_percent(pct_t'(1));
		send_score(10'd9);
		send_score(10'd10);

		for (int ph = 0; ph < 8; ph++) begin
			write_percent(phase_pct(ph));
			case (ph % 4)
				0: begin send_idle = 0;  stall_rate <= 0;  end
				1: begin send_idle = 65; stall_rate <= 0;  end
				2: begin send_idle = 0;  stall_rate <= 65; end
				default: begin send_idle = 32; stall_rate <= 32; end
			endcase
			hot_base = score_t'($urandom_range(1023));
			for (int i = 0; i < 70; i++) begin
				send_score(pick_score(hot_base));
			end
		end

		drain();
		repeat (1100) @(posedge clk);
		$display("run covered %0d scores across %0d percent writes", n_sent, n_cfg);
		$display("pacing: free flow, idle sender, stalling receiver and both together");
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
